/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl of the trailing zeros block
// expects clk and rst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define FZB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true outside reset
`define FZB_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/fzb_pkg.sv */
// shared types and constants of the factorial trailing zeros block
// no dependencies
`timescale 1ns / 1ps

package fzb_pkg;

    localparam int N_BITS    = 21;
    localparam int BASE_W    = 10;
    localparam int ZEROS_W   = 20;
    localparam int MAX_PRIME = 29;
    localparam int D_W       = $clog2(MAX_PRIME + 2);
    localparam int E_W       = 4;
    localparam int CNT_W     = $clog2(N_BITS + 1);

    localparam logic [ZEROS_W-1:0] ZEROS_MAX = {ZEROS_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRIAL_CHECK,
        ST_TRIAL_WAIT,
        ST_LEFTOVER,
        ST_LEG_START,
        ST_LEG_WAIT,
        ST_EDIV_WAIT,
        ST_TAKE_MIN,
        ST_FINISH
    } fzb_state_t;

    typedef struct packed {
        logic              start;
        logic [N_BITS-1:0] dividend;
        logic [BASE_W-1:0] divisor;
    } fzb_div_req_t;

    typedef struct packed {
        logic              done;
        logic [N_BITS-1:0] quotient;
        logic [BASE_W-1:0] remainder;
    } fzb_div_rsp_t;

endpackage

/* rtl/factorial_trailing_zeros_base_b.sv */
// top level: trailing zeros of n! in base b, sequencer around one shared divider
// depends on fzb_pkg, fzb_div and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// usage
// - input channel in_valid / in_ready carries n_value and base; output channel
//   out_valid / out_ready carries zeros, one result per request
// - base is factored by trial division with divisors 2..29, stopping once the
//   divisor squared exceeds what is left; a leftover above 1 is one more prime
// - for each prime p with exponent e the sum of floor(n / p^k) is built by
//   repeated division of the running quotient by p, then divided by e
// - every division runs on one restoring divider, one bit per cycle, so the
//   latency grows with the number of divisions and of prime factors of base
// - the division count grows with the number of prime factors of base and with
//   log_p(n), up to about 63 divisions for base 840 with n near 2^21; a base
//   below 2 needs no division
// - in_ready is high only in idle, one request is in flight at a time
// - a finished result sits in the output register; while the receiver stalls,
//   the next request may be taken and worked on, and its result waits until
//   the held one is taken
// - counts above the output range saturate at all ones
// - reset (rst_n, asynchronous, active low) returns to idle with no result held
module factorial_trailing_zeros_base_b
    import fzb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [N_BITS-1:0]  n_value,
    input  logic [BASE_W-1:0]  base,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ZEROS_W-1:0] zeros
);

    fzb_state_t         state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    logic [ZEROS_W-1:0] zeros_reg, zeros_next;

    // per request working registers
    logic [N_BITS-1:0]  n_reg, n_next;       // factorial argument
    logic [BASE_W-1:0]  rem_reg, rem_next;   // unfactored part of the base
    logic [D_W-1:0]     d_reg, d_next;       // trial divisor
    logic [E_W-1:0]     e_reg, e_next;       // exponent of current prime
    logic [BASE_W-1:0]  p_reg, p_next;       // current prime
    logic [N_BITS-1:0]  sum_reg, sum_next;   // legendre sum
    logic [N_BITS-1:0]  cand_reg, cand_next; // sum divided by exponent
    logic [N_BITS-1:0]  best_reg, best_next; // running minimum
    logic               have_reg, have_next;
    logic               last_reg, last_next; // working on the leftover prime

    fzb_div_req_t       div_req;
    fzb_div_rsp_t       div_rsp;

    logic [2*D_W-1:0]   d_sq;
    logic [ZEROS_W-1:0] best_sat;

    // used by the checks at the end
    logic               in_fire;
    logic               div_waiting;

    assign d_sq     = {{D_W{1'b0}}, d_reg} * {{D_W{1'b0}}, d_reg};
    assign best_sat = (best_reg > N_BITS'(ZEROS_MAX)) ? ZEROS_MAX : best_reg[ZEROS_W-1:0];

    fzb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        zeros_next     = zeros_reg;
        n_next         = n_reg;
        rem_next       = rem_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        p_next         = p_reg;
        sum_next       = sum_reg;
        cand_next      = cand_reg;
        best_next      = best_reg;
        have_next      = have_reg;
        last_next      = last_reg;
        in_ready       = 1'b0;
        div_req        = '0;

        // held result leaves when taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    n_next    = n_value;
                    rem_next  = base;
                    best_next = '0;
                    have_next = 1'b0;
                    last_next = 1'b0;
                    d_next    = D_W'(2);
                    // base below 2 has no factors, answer is zero
                    state_next = (base < BASE_W'(2)) ? ST_FINISH : ST_TRIAL_CHECK;
                end
            end

            ST_TRIAL_CHECK:
            begin
                if ((d_reg > D_W'(MAX_PRIME)) || (d_sq > rem_reg))
                begin
                    state_next = ST_LEFTOVER;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = N_BITS'(rem_reg);
                    div_req.divisor  = BASE_W'(d_reg);
                    e_next           = '0;
                    state_next       = ST_TRIAL_WAIT;
                end
            end

            ST_TRIAL_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.remainder == '0)
                    begin
                        // divides evenly: strip the factor and try again
                        rem_next         = div_rsp.quotient[BASE_W-1:0];
                        e_next           = e_reg + E_W'(1);
                        div_req.start    = 1'b1;
                        div_req.dividend = div_rsp.quotient;
                        div_req.divisor  = BASE_W'(d_reg);
                    end
                    else if (e_reg != '0)
                    begin
                        p_next     = BASE_W'(d_reg);
                        state_next = ST_LEG_START;
                    end
                    else
                    begin
                        d_next     = d_reg + D_W'(1);
                        state_next = ST_TRIAL_CHECK;
                    end
                end
            end

            ST_LEFTOVER:
            begin
                if (rem_reg > BASE_W'(1))
                begin
                    p_next     = rem_reg;
                    e_next     = E_W'(1);
                    last_next  = 1'b1;
                    state_next = ST_LEG_START;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_LEG_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = n_reg;
                div_req.divisor  = p_reg;
                sum_next         = '0;
                state_next       = ST_LEG_WAIT;
            end

            ST_LEG_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient == '0)
                    begin
                        if (e_reg == E_W'(1))
                        begin
                            cand_next  = sum_reg;
                            state_next = ST_TAKE_MIN;
                        end
                        else
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = sum_reg;
                            div_req.divisor  = BASE_W'(e_reg);
                            state_next       = ST_EDIV_WAIT;
                        end
                    end
                    else
                    begin
                        // floor(n / p^k) = floor(floor(n / p^(k-1)) / p)
                        sum_next         = sum_reg + div_rsp.quotient;
                        div_req.start    = 1'b1;
                        div_req.dividend = div_rsp.quotient;
                        div_req.divisor  = p_reg;
                    end
                end
            end

            ST_EDIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    cand_next  = div_rsp.quotient;
                    state_next = ST_TAKE_MIN;
                end
            end

            ST_TAKE_MIN:
            begin
                if (!have_reg || (cand_reg < best_reg))
                begin
                    best_next = cand_reg;
                end
                have_next = 1'b1;
                if (last_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    d_next     = d_reg + D_W'(1);
                    state_next = ST_TRIAL_CHECK;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    zeros_next     = best_sat;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zeros_reg <= zeros_next;
        n_reg     <= n_next;
        rem_reg   <= rem_next;
        d_reg     <= d_next;
        e_reg     <= e_next;
        p_reg     <= p_next;
        sum_reg   <= sum_next;
        cand_reg  <= cand_next;
        best_reg  <= best_next;
        have_reg  <= have_next;
        last_reg  <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign zeros     = zeros_reg;

    assign in_fire     = in_valid && in_ready;
    assign div_waiting = (state_reg == ST_TRIAL_WAIT) || (state_reg == ST_LEG_WAIT)
                         || (state_reg == ST_EDIV_WAIT);

    `FZB_ASSERT(a_accept_starts_work, in_fire |=> (state_reg != ST_IDLE), "request not started")
    `FZB_ASSERT(a_done_in_wait, div_rsp.done |-> div_waiting, "divider done outside a wait state")
    `FZB_ASSERT(a_leg_has_exp, (state_reg == ST_LEG_WAIT) |-> (e_reg != '0), "zero exponent")
    `FZB_ASSERT(a_min_after_factor, (state_reg == ST_TAKE_MIN) |=> have_reg, "minimum not marked")

endmodule

/* rtl/fzb_div.sv */
// shared restoring divider, one quotient bit per cycle
// depends on fzb_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fzb_div
    import fzb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  fzb_div_req_t req,
    output fzb_div_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [N_BITS-1:0] quo_reg, quo_next;
    logic [BASE_W-1:0] part_reg, part_next;
    logic [BASE_W-1:0] dsr_reg, dsr_next;

    logic [BASE_W:0]   trial;
    logic [BASE_W:0]   diff;
    logic              fits;

    assign trial = {part_reg, quo_reg[N_BITS-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        part_next = part_reg;
        dsr_next  = dsr_reg;
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(N_BITS);
            quo_next  = req.dividend;
            part_next = '0;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[N_BITS-2:0], fits};
            part_next = fits ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        part_reg <= part_next;
        dsr_reg  <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = part_reg;

    `FZB_ASSERT_NEVER(a_start_while_busy, req.start && busy_reg, "divider started while busy")
    `FZB_ASSERT(a_done_after_busy, done_reg |-> $past(busy_reg), "done without a running division")

endmodule

/* dv/fzb_zeros_checker.sv */
// checker for the factorial trailing zeros block: predicts zeros for each accepted request
// and compares every result in order; depends on fzb_pkg
`timescale 1ns / 1ps

module fzb_zeros_checker
    import fzb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [N_BITS-1:0]  n_value,
    input  logic [BASE_W-1:0]  base,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [ZEROS_W-1:0] zeros,
    output int                 fail_count,
    output int                 pending_count,
    output int                 checked_count
);

    typedef struct packed {
        logic [N_BITS-1:0]  n;
        logic [BASE_W-1:0]  b;
        logic [ZEROS_W-1:0] zeros;
    } zeros_entry_t;

    zeros_entry_t zeros_due_q[$];
    zeros_entry_t entry;

    // exponent of p in n! as the sum of floor(n / p^k)
    function automatic longint unsigned prime_exp_in_factorial(longint unsigned n,
                                                               longint unsigned p);
        longint unsigned pw;
        longint unsigned total;
        pw    = p;
        total = 0;
        if (p < 2)
            return 0;
        while (pw <= n)
        begin
            total += n / pw;
            if (pw > n / p)
                break;
            pw *= p;
        end
        return total;
    endfunction

    function automatic logic [ZEROS_W-1:0] predict_zeros(logic [N_BITS-1:0] n,
                                                         logic [BASE_W-1:0] b);
        longint unsigned nn;
        longint unsigned rest;
        longint unsigned best;
        longint unsigned cand;
        int unsigned     mult;
        bit              found;
        nn    = n;
        rest  = b;
        best  = 0;
        found = 1'b0;
        if (rest >= 2)
        begin
            for (int d = 2; d <= MAX_PRIME; d++)
            begin
                if (longint'(d * d) > rest)
                    break;
                mult = 0;
                while (rest % d == 0)
                begin
                    rest /= d;
                    mult++;
                end
                if (mult != 0)
                begin
                    cand = prime_exp_in_factorial(nn, d) / mult;
                    if (!found || cand < best)
                        best = cand;
                    found = 1'b1;
                end
            end
            // leftover above one is taken as a single prime
            if (rest > 1)
            begin
                cand = prime_exp_in_factorial(nn, rest);
                if (!found || cand < best)
                    best = cand;
                found = 1'b1;
            end
        end
        if (best > ZEROS_MAX)
            best = ZEROS_MAX;
        return best[ZEROS_W-1:0];
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            fail_count    = 0;
            pending_count = 0;
            checked_count = 0;
        end
        else
        begin
            // results first, so a request taken in the same cycle is never matched
            if (out_valid && out_ready)
            begin
                if (zeros_due_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with no request pending, expected none, actual %0d",
                             $time, zeros);
                end
                else
                begin
                    entry = zeros_due_q.pop_front();
                    checked_count++;
                    if (zeros !== entry.zeros)
                    begin
                        fail_count++;
                        $display("%0t: zeros mismatch n=%0d base=%0d expected %0d actual %0d",
                                 $time, entry.n, entry.b, entry.zeros, zeros);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                entry.n     = n_value;
                entry.b     = base;
                entry.zeros = predict_zeros(n_value, base);
                zeros_due_q.insert(zeros_due_q.size(), entry);
            end
            pending_count = zeros_due_q.size();
        end
    end

endmodule

/* dv/tb_top.sv */
// testbench top for factorial_trailing_zeros_base_b: directed and random requests,
// random idling on both channels, verdict; depends on fzb_pkg and fzb_zeros_checker
`timescale 1ns / 1ps

module tb_top;
    import fzb_pkg::*;

    // random requests after the directed ones
    localparam int RANDOM_REQUESTS = 1825;
    // no idling on either side for the last requests
    localparam int CALM_REQUESTS   = 150;
    // worst request is about 63 divisions plus idling
    localparam int CYCLE_LIMIT     = 25_000_000;
    // after the last result, long enough for one more slow request to show up
    localparam int DRAIN_CYCLES    = 2500;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [N_BITS-1:0]  n_value;
    logic [BASE_W-1:0]  base;
    logic               out_valid;
    logic               out_ready;
    logic [ZEROS_W-1:0] zeros;

    int fail_count;
    int pending_count;
    int checked_count;
    int sent_count;
    int cycle_count;
    int stall_pct;
    int rx_cycle;
    bit calm_tail;

    factorial_trailing_zeros_base_b u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .n_value   (n_value),
        .base      (base),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .zeros     (zeros)
    );

    // watches both channels, predicts and compares
    fzb_zeros_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .n_value       (n_value),
        .base          (base),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .zeros         (zeros),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    // 4 ns clock
    initial
        clk = 1'b0;
    always #2 clk = ~clk;

    // present one request at a falling edge and hold it until it is taken;
    // returns at the falling edge after acceptance with valid still high
    task automatic send_request(input logic [N_BITS-1:0] n, input logic [BASE_W-1:0] b);
        in_valid = 1'b1;
        n_value  = n;
        base     = b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    // receiver: ready drops in bursts of random length; the stall rate is redrawn
    // among 0, 3 and 12 percent at regular intervals so some stretches see no stalls at all
    initial
    begin
        out_ready = 1'b0;
        stall_pct = 5;
        rx_cycle  = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle % 300 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 3;
                    default: stall_pct = 12;
                endcase
            end
            if (!calm_tail && $urandom_range(0, 99) < stall_pct)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 15))
                    @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    // cycle counter, ends a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d results still due",
                 cycle_count, pending_count);
        $display("status: fail");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        int unsigned pick;
        int unsigned pick_n;
        int unsigned pick_b;
        int unsigned factor;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        n_value    = '0;
        base       = '0;
        sent_count = 0;
        calm_tail  = 1'b0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part
        send_request(21'd0,       10'd2);    // n zero
        send_request(21'd1,       10'd2);    // n one, nothing divides
        send_request(21'd1,       10'd10);
        send_request(21'd100,     10'd10);   // classic 24 zeros
        send_request(21'd2097151, 10'd2);    // largest n, saturates
        send_request(21'd1048576, 10'd2);    // lands exactly on the top of the range
        send_request(21'd1048576, 10'd4);    // squared prime, exponent division
        send_request(21'd2097151, 10'd3);
        send_request(21'd12345,   10'd0);    // radix zero
        send_request(21'd12345,   10'd1);    // radix one
        send_request(21'd0,       10'd1023);
        send_request(21'd2097151, 10'd1023); // 3 * 11 * 31, leftover prime 31
        send_request(21'd2097151, 10'd961);  // 31 squared acts as one prime
        send_request(21'd500,     10'd1021); // prime above the divisor list
        send_request(21'd1048575, 10'd512);  // high power of two
        send_request(21'd2097151, 10'd729);  // power of three
        send_request(21'd1000,    10'd841);  // 29 squared, divisor squared equals rest
        send_request(21'd1000,    10'd899);  // 29 * 31
        send_request(21'd30,      10'd31);
        send_request(21'd50,      10'd30);
        send_request(21'd1000000, 10'd960);  // upper end of the exact radix range
        send_request(21'd2097151, 10'd210);  // four distinct primes
        send_request(21'd2097151, 10'd510);
        send_request(21'd999,     10'd1000);
        send_request(21'd720,     10'd720);

        // random part
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            calm_tail = (i >= RANDOM_REQUESTS - CALM_REQUESTS);
            if (!calm_tail && $urandom_range(0, 3) == 0)
            begin
                in_valid = 1'b0;
                repeat ($urandom_range(1, 15))
                    @(negedge clk);
            end

            // small n in four picks of ten keeps many legendre loops short
            pick = $urandom_range(0, 9);
            if (pick < 4)
                pick_n = $urandom_range(0, 1023);
            else if (pick < 7)
                pick_n = $urandom_range(0, 1048576);
            else if (pick < 9)
                pick_n = $urandom_range(0, 2097151);
            else
                pick_n = (32'd1 << $urandom_range(1, 20)) - 1 + $urandom_range(0, 2);

            // radix: mostly the exact range, some above it, some below two,
            // some prime powers to exercise the exponent division
            pick = $urandom_range(0, 19);
            if (pick < 15)
                pick_b = $urandom_range(2, 960);
            else if (pick < 17)
                pick_b = $urandom_range(961, 1023);
            else if (pick < 18)
                pick_b = $urandom_range(0, 1);
            else
            begin
                case ($urandom_range(0, 5))
                    0:       factor = 2;
                    1:       factor = 3;
                    2:       factor = 5;
                    3:       factor = 7;
                    4:       factor = 29;
                    default: factor = 31;
                endcase
                pick_b = 1;
                repeat ($urandom_range(1, 9))
                    if (pick_b * factor <= 1023)
                        pick_b = pick_b * factor;
                if (pick_b < 2)
                    pick_b = factor;
            end

            send_request(pick_n[N_BITS-1:0], pick_b[BASE_W-1:0]);
        end
        in_valid = 1'b0;

        // drain, then give a stray result time to appear
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);

        $display("ran %0d requests over n up to 2^21-1 and radix 0 to 1023, %0d results checked",
                 sent_count, checked_count);
        $display("%0d failures, %0d results left unanswered", fail_count, pending_count);
        if (fail_count == 0 && pending_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
